/* design/rbp_pkg.sv */
package rbp_pkg;

  localparam int PIXEL_W  = 24;
  localparam int COORD_W  = 11;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 3;
  localparam int MARGIN_W = 3;

  localparam int DEF_MAX_DIM    = 1024;
  localparam int DEF_CHANNELS   = 3;
  localparam int DEF_MAX_MARGIN = 7;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_LEFT_MARGIN   = 3'd2,
    REG_RIGHT_MARGIN  = 3'd3,
    REG_TOP_MARGIN    = 3'd4,
    REG_BOTTOM_MARGIN = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [MARGIN_W-1:0] left;
    logic [MARGIN_W-1:0] right;
    logic [MARGIN_W-1:0] top;
    logic [MARGIN_W-1:0] bottom;
  } margin_t;

endpackage

/* design/rbp_if.sv */
interface rbp_pixel_if;
  import rbp_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface rbp_write_if;
  import rbp_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic [PIXEL_W-1:0] out_pixel;
  logic               burst_last;

  modport source (output valid, output out_col, output out_row, output out_pixel,
                  output burst_last, input ready);
  modport sink   (input valid, input out_col, input out_row, input out_pixel,
                  input burst_last, output ready);
endinterface

/* design/rbp_cfg.sv */
module rbp_cfg import rbp_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int MAX_MARGIN = DEF_MAX_MARGIN,
  localparam int CNT_W     = $clog2(MAX_DIM)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 cfg_hit_o,
  output logic [CNT_W-1:0]     last_col_o,
  output logic [CNT_W-1:0]     last_row_o,
  output margin_t              margin_o
);

  function automatic logic [CNT_W-1:0] dim_last(input int v);
    int c;
    begin
      c = v;
      if (c < 2) c = 2;
      if (c > MAX_DIM) c = MAX_DIM;
      dim_last = CNT_W'(c - 1);
    end
  endfunction

  function automatic logic [MARGIN_W-1:0] clamp_margin(input logic [MARGIN_W-1:0] v);
    begin
      if (int'(v) > MAX_MARGIN) clamp_margin = MARGIN_W'(MAX_MARGIN);
      else clamp_margin = v;
    end
  endfunction

  localparam logic [CNT_W-1:0] RESET_LAST_COL = dim_last(RESET_WIDTH);
  localparam logic [CNT_W-1:0] RESET_LAST_ROW = dim_last(RESET_HEIGHT);

  logic [CNT_W-1:0]    last_col_q, last_col_d;
  logic [CNT_W-1:0]    last_row_q, last_row_d;
  margin_t             margin_q, margin_d;
  logic                hit;
  logic [MARGIN_W-1:0] m_val;

  assign m_val = clamp_margin(cfg_data_i[MARGIN_W-1:0]);

  always_comb begin
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    margin_d   = margin_q;
    hit        = 1'b0;
    if (cfg_we_i) begin
      hit = 1'b1;
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:   last_col_d = dim_last(int'(cfg_data_i));
        REG_IMAGE_HEIGHT:  last_row_d = dim_last(int'(cfg_data_i));
        REG_LEFT_MARGIN:   margin_d.left = m_val;
        REG_RIGHT_MARGIN:  margin_d.right = m_val;
        REG_TOP_MARGIN:    margin_d.top = m_val;
        REG_BOTTOM_MARGIN: margin_d.bottom = m_val;
        default:           hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= RESET_LAST_COL;
      last_row_q <= RESET_LAST_ROW;
      margin_q   <= '0;
    end else begin
      last_col_q <= last_col_d;
      last_row_q <= last_row_d;
      margin_q   <= margin_d;
    end
  end

  assign cfg_hit_o  = hit;
  assign last_col_o = last_col_q;
  assign last_row_o = last_row_q;
  assign margin_o   = margin_q;

endmodule

/* design/rbp_pos.sv */
module rbp_pos import rbp_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int MAX_MARGIN = DEF_MAX_MARGIN,
  localparam int CNT_W     = $clog2(MAX_DIM),
  localparam int POS_W     = $clog2(MAX_DIM + 2 * MAX_MARGIN + 2)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rbp_pixel_if.sink          pixel_i,
  input  logic               cfg_hit_i,
  input  logic [CNT_W-1:0]   last_col_i,
  input  logic [CNT_W-1:0]   last_row_i,
  input  margin_t            margin_i,
  output logic               job_valid_o,
  input  logic               job_take_i,
  output logic [POS_W-1:0]   job_col_lo_o,
  output logic [POS_W-1:0]   job_col_hi_o,
  output logic [POS_W-1:0]   job_row_lo_o,
  output logic [POS_W-1:0]   job_row_hi_o,
  output logic [PIXEL_W-1:0] job_pixel_o
);

  localparam int CH_BITS = 8 * CHANNELS;

  logic [CNT_W-1:0]   col_q, col_d, row_q, row_d;
  logic               job_valid_q, job_valid_d;
  logic [POS_W-1:0]   col_lo_q, col_hi_q, row_lo_q, row_hi_q;
  logic [POS_W-1:0]   col_base, row_base, col_lo_d, col_hi_d, row_lo_d, row_hi_d;
  logic [PIXEL_W-1:0] pixel_q, pixel_d;
  logic               accept, at_last_col, at_last_row;

  assign pixel_i.ready = !job_valid_q || job_take_i;
  assign accept        = pixel_i.valid && pixel_i.ready;
  assign at_last_col   = (col_q == last_col_i);
  assign at_last_row   = (row_q == last_row_i);

  always_comb begin
    col_base = POS_W'(margin_i.left) + POS_W'(col_q);
    row_base = POS_W'(margin_i.top) + POS_W'(row_q);
    col_lo_d = (col_q == '0) ? '0 : col_base;
    col_hi_d = at_last_col ? col_base + POS_W'(margin_i.right) : col_base;
    row_lo_d = (row_q == '0) ? '0 : row_base;
    row_hi_d = at_last_row ? row_base + POS_W'(margin_i.bottom) : row_base;
    for (int i = 0; i < PIXEL_W; i++) begin
      pixel_d[i] = pixel_i.pixel[i] && (i < CH_BITS);
    end
  end

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    job_valid_d = job_valid_q;
    if (job_take_i) job_valid_d = 1'b0;
    if (cfg_hit_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      job_valid_d = 1'b1;
      if (at_last_col) begin
        col_d = '0;
        row_d = at_last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      job_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_lo_q <= col_lo_d;
      col_hi_q <= col_hi_d;
      row_lo_q <= row_lo_d;
      row_hi_q <= row_hi_d;
      pixel_q  <= pixel_d;
    end
  end

  assign job_valid_o  = job_valid_q;
  assign job_col_lo_o = col_lo_q;
  assign job_col_hi_o = col_hi_q;
  assign job_row_lo_o = row_lo_q;
  assign job_row_hi_o = row_hi_q;
  assign job_pixel_o  = pixel_q;

endmodule

/* design/rbp_walk.sv */
module rbp_walk import rbp_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int MAX_MARGIN = DEF_MAX_MARGIN,
  localparam int POS_W     = $clog2(MAX_DIM + 2 * MAX_MARGIN + 2)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_take_o,
  input  logic [POS_W-1:0]   job_col_lo_i,
  input  logic [POS_W-1:0]   job_col_hi_i,
  input  logic [POS_W-1:0]   job_row_lo_i,
  input  logic [POS_W-1:0]   job_row_hi_i,
  input  logic [PIXEL_W-1:0] job_pixel_i,
  rbp_write_if.source        write_o
);

  logic               valid_q, valid_d;
  logic [POS_W-1:0]   x_q, x_d, y_q, y_d;
  logic [POS_W-1:0]   col_lo_q, col_lo_d, col_hi_q, col_hi_d, row_hi_q, row_hi_d;
  logic [PIXEL_W-1:0] pixel_q, pixel_d;
  logic               last_q, last_d;
  logic               advance, load;

  assign advance    = !valid_q || write_o.ready;
  assign load       = advance && (!valid_q || last_q);
  assign job_take_o = load && job_valid_i;

  always_comb begin
    valid_d  = valid_q;
    x_d      = x_q;
    y_d      = y_q;
    col_lo_d = col_lo_q;
    col_hi_d = col_hi_q;
    row_hi_d = row_hi_q;
    pixel_d  = pixel_q;
    last_d   = last_q;
    if (load) begin
      valid_d  = job_valid_i;
      x_d      = job_col_lo_i;
      y_d      = job_row_lo_i;
      col_lo_d = job_col_lo_i;
      col_hi_d = job_col_hi_i;
      row_hi_d = job_row_hi_i;
      pixel_d  = job_pixel_i;
      last_d   = (job_col_lo_i == job_col_hi_i) && (job_row_lo_i == job_row_hi_i);
    end else if (advance) begin
      if (x_q == col_hi_q) begin
        x_d = col_lo_q;
        y_d = y_q + 1'b1;
      end else begin
        x_d = x_q + 1'b1;
      end
      last_d = (x_d == col_hi_q) && (y_d == row_hi_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    col_lo_q <= col_lo_d;
    col_hi_q <= col_hi_d;
    row_hi_q <= row_hi_d;
    pixel_q  <= pixel_d;
    last_q   <= last_d;
  end

  assign write_o.valid      = valid_q;
  assign write_o.out_col    = COORD_W'(x_q);
  assign write_o.out_row    = COORD_W'(y_q);
  assign write_o.out_pixel  = pixel_q;
  assign write_o.burst_last = last_q;

endmodule

/* design/replicate_border_padder_top.sv */
// Replicate-border padder. Source pixels arrive in raster order on pixel_i, one
// per transaction; the block counts column and row itself. For each pixel it
// emits on write_o a burst of frame-buffer writes (padded column, padded row,
// pixel value) for its own place and every margin place that copies it, in
// order of rising row and then rising column, with burst_last on the final one.
// A pixel is captured into a job register, and the burst generator walks the
// job's rectangle one write per cycle while the receiver is ready into the
// output register, so a pixel's first write passes both registers. Interior
// pixels sustain one transaction per cycle while the receiver is ready; pixel_i
// stalls while an edge burst (up to 64 writes for a full-margin corner) runs.
// When the receiver deasserts ready the output register holds its write, the
// job register fills and then pixel_i.ready falls; nothing is dropped.
// Reset clears the counters and loads width 640, height 480 and zero margins.
// Configuration writes to a defined index through cfg_we_i, cfg_idx_i and
// cfg_data_i take effect at once and restart the frame at its first pixel;
// the user must issue them only while the block is idle; it is not enforced.
module replicate_border_padder_top import rbp_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int MAX_MARGIN = DEF_MAX_MARGIN
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  rbp_pixel_if.sink            pixel_i,
  rbp_write_if.source          write_o
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int POS_W = $clog2(MAX_DIM + 2 * MAX_MARGIN + 2);

  logic               cfg_hit;
  logic [CNT_W-1:0]   last_col, last_row;
  margin_t            margin;
  logic               job_valid, job_take;
  logic [POS_W-1:0]   job_col_lo, job_col_hi, job_row_lo, job_row_hi;
  logic [PIXEL_W-1:0] job_pixel;

  rbp_cfg #(
    .MAX_DIM    (MAX_DIM),
    .MAX_MARGIN (MAX_MARGIN)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_hit_o  (cfg_hit),
    .last_col_o (last_col),
    .last_row_o (last_row),
    .margin_o   (margin)
  );

  rbp_pos #(
    .MAX_DIM    (MAX_DIM),
    .CHANNELS   (CHANNELS),
    .MAX_MARGIN (MAX_MARGIN)
  ) u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pixel_i      (pixel_i),
    .cfg_hit_i    (cfg_hit),
    .last_col_i   (last_col),
    .last_row_i   (last_row),
    .margin_i     (margin),
    .job_valid_o  (job_valid),
    .job_take_i   (job_take),
    .job_col_lo_o (job_col_lo),
    .job_col_hi_o (job_col_hi),
    .job_row_lo_o (job_row_lo),
    .job_row_hi_o (job_row_hi),
    .job_pixel_o  (job_pixel)
  );

  rbp_walk #(
    .MAX_DIM    (MAX_DIM),
    .MAX_MARGIN (MAX_MARGIN)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_take_o   (job_take),
    .job_col_lo_i (job_col_lo),
    .job_col_hi_i (job_col_hi),
    .job_row_lo_i (job_row_lo),
    .job_row_hi_i (job_row_hi),
    .job_pixel_i  (job_pixel),
    .write_o      (write_o)
  );

endmodule

/* tb/sv/rbp_padding_checker.sv */
module rbp_padding_checker import rbp_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int MAX_MARGIN = DEF_MAX_MARGIN
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  rbp_pixel_if                 pixel_mon,
  rbp_write_if                 write_mon,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIXEL_W-1:0] pixel;
    logic               last;
  } pad_write_t;

  logic [CFG_W-1:0]    width_q;
  logic [CFG_W-1:0]    height_q;
  logic [MARGIN_W-1:0] left_q;
  logic [MARGIN_W-1:0] right_q;
  logic [MARGIN_W-1:0] top_q;
  logic [MARGIN_W-1:0] bottom_q;
  int unsigned         col_cnt;
  int unsigned         row_cnt;
  int                  fails;
  pad_write_t          expected_writes[$];

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned clamp_margin(input logic [MARGIN_W-1:0] v);
    return (v > MAX_MARGIN) ? MAX_MARGIN : v;
  endfunction

  task automatic queue_burst(input logic [PIXEL_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned col_lo;
    int unsigned col_hi;
    int unsigned row_lo;
    int unsigned row_hi;
    logic [PIXEL_W-1:0] mask;
    pad_write_t wr;
    w = clamp_dim(width_q);
    h = clamp_dim(height_q);
    mask = (CHANNELS >= 3) ? '1 : PIXEL_W'((64'd1 << (8 * CHANNELS)) - 1);
    col_lo = clamp_margin(left_q) + col_cnt;
    col_hi = col_lo;
    if (col_cnt == 0) col_lo = 0;
    if (col_cnt == w - 1) col_hi = col_hi + clamp_margin(right_q);
    row_lo = clamp_margin(top_q) + row_cnt;
    row_hi = row_lo;
    if (row_cnt == 0) row_lo = 0;
    if (row_cnt == h - 1) row_hi = row_hi + clamp_margin(bottom_q);
    for (int unsigned y = row_lo; y <= row_hi; y++) begin
      for (int unsigned x = col_lo; x <= col_hi; x++) begin
        wr.col   = COORD_W'(x);
        wr.row   = COORD_W'(y);
        wr.pixel = pix & mask;
        wr.last  = (y == row_hi) && (x == col_hi);
        expected_writes.push_back(wr);
      end
    end
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : ((row_cnt + 1) & 10'h3FF);
    end else begin
      col_cnt = (col_cnt + 1) & 10'h3FF;
    end
  endtask

  task automatic compare_write();
    pad_write_t got;
    pad_write_t exp_wr;
    got.col   = write_mon.out_col;
    got.row   = write_mon.out_row;
    got.pixel = write_mon.out_pixel;
    got.last  = write_mon.burst_last;
    if (expected_writes.size() == 0) begin
      $display("%0t: unexpected write col %0d row %0d pixel %06h last %0b", $time,
               got.col, got.row, got.pixel, got.last);
      fails++;
    end else begin
      exp_wr = expected_writes.pop_front();
      if (got.col !== exp_wr.col || got.row !== exp_wr.row ||
          got.pixel !== exp_wr.pixel || got.last !== exp_wr.last) begin
        $display("%0t: write mismatch, expected col %0d row %0d pixel %06h last %0b, got col %0d row %0d pixel %06h last %0b",
                 $time, exp_wr.col, exp_wr.row, exp_wr.pixel, exp_wr.last,
                 got.col, got.row, got.pixel, got.last);
        fails++;
      end
    end
  endtask

  task automatic apply_register();
    case (cfg_idx_i)
      REG_IMAGE_WIDTH:   width_q  = cfg_data_i;
      REG_IMAGE_HEIGHT:  height_q = cfg_data_i;
      REG_LEFT_MARGIN:   left_q   = cfg_data_i[MARGIN_W-1:0];
      REG_RIGHT_MARGIN:  right_q  = cfg_data_i[MARGIN_W-1:0];
      REG_TOP_MARGIN:    top_q    = cfg_data_i[MARGIN_W-1:0];
      REG_BOTTOM_MARGIN: bottom_q = cfg_data_i[MARGIN_W-1:0];
      default:           return;
    endcase
    col_cnt = 0;
    row_cnt = 0;
  endtask

  // A write transaction can never belong to a pixel accepted at the same edge,
  // so the comparison is made before the new burst is queued.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  = CFG_W'(RESET_WIDTH);
      height_q = CFG_W'(RESET_HEIGHT);
      left_q   = '0;
      right_q  = '0;
      top_q    = '0;
      bottom_q = '0;
      col_cnt  = 0;
      row_cnt  = 0;
      expected_writes.delete();
    end else begin
      if (write_mon.valid && write_mon.ready) compare_write();
      if (cfg_we_i) apply_register();
      if (pixel_mon.valid && pixel_mon.ready) queue_burst(pixel_mon.pixel);
    end
    fail_count_o = fails;
    pending_o    = expected_writes.size();
  end

  initial begin
    fails        = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end
endmodule

/* tb/sv/tb_replicate_border_padder_top.sv */
module tb_replicate_border_padder_top import rbp_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending_writes;
  int                   cycle_count;
  int                   send_idle_pct;
  int                   recv_idle_pct;

  rbp_pixel_if pixel_ch ();
  rbp_write_if write_ch ();

  replicate_border_padder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pixel_i    (pixel_ch),
    .write_o    (write_ch)
  );

  rbp_padding_checker u_padding_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pixel_mon    (pixel_ch),
    .write_mon    (write_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_writes)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    write_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.pixel <= pix;
    do @(posedge clk_i); while (!pixel_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    pixel_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_writes != 0) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] margin_word(input int unsigned m);
    return {CFG_W'($urandom_range(0, 255)) << MARGIN_W} | CFG_W'(m);
  endfunction

  task automatic load_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                               input int unsigned l, input int unsigned r,
                               input int unsigned t, input int unsigned b);
    wait_for_drain();
    write_register(REG_IMAGE_WIDTH, w);
    write_register(REG_IMAGE_HEIGHT, h);
    write_register(REG_LEFT_MARGIN, margin_word(l));
    write_register(REG_RIGHT_MARGIN, margin_word(r));
    write_register(REG_TOP_MARGIN, margin_word(t));
    write_register(REG_BOTTOM_MARGIN, margin_word(b));
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mid-frame pause; a write to an unused index must leave the position alone.
  task automatic pause_frame(input bit poke_spare);
    wait_for_drain();
    if (poke_spare) begin
      write_register($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                     CFG_W'($urandom_range(0, 2047)));
      cfg_we <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return CFG_W'($urandom_range(0, 2047));
      1:       return CFG_W'($urandom_range(0, 1));
      default: return CFG_W'($urandom_range(2, 8));
    endcase
  endfunction

  initial begin
    cycle_count    = 0;
    send_idle_pct  = 6;
    recv_idle_pct  = 64;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_IMAGE_WIDTH;
    cfg_data       = '0;
    pixel_ch.valid = 1'b0;
    pixel_ch.pixel = '0;
    write_ch.ready = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'hA5A5A5);

    load_geometry(11'd2, 11'd2, 7, 7, 7, 7);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'h123456);
    send_pixel(24'hFEDCBA);
    send_pixel(24'h800001);

    load_geometry(11'd0, 11'd1, 0, 7, 3, 0);
    send_pixel(24'h5A5A5A);
    send_pixel(24'h0F0F0F);
    send_pixel(24'hF0F0F0);
    pause_frame(1'b1);
    send_pixel(24'h7FFFFF);
    send_pixel(24'h000001);

    load_geometry(11'h7FF, 11'h7FF, 7, 0, 0, 7);
    send_pixel(24'hC3C3C3);
    send_pixel(24'h3C3C3C);
    send_pixel(24'h010203);

    load_geometry(11'd1024, 11'd1025, 1, 2, 5, 6);
    send_pixel(24'hFFFFFE);
    send_pixel(24'h00FF00);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 64 : 0;
      recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 6 : 0;
      for (int s = 0; s < 4; s++) begin
        load_geometry(pick_dim(), pick_dim(), $urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(0, 7), $urandom_range(0, 7));
        for (int n = 0; n < 25; n++) begin
          if ($urandom_range(0, 39) == 0) pause_frame($urandom_range(0, 1));
          send_pixel(PIXEL_W'($urandom()));
        end
      end
    end

    wait_for_drain();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

/* sim.f */
design/rbp_pkg.sv
design/rbp_if.sv
design/rbp_cfg.sv
design/rbp_pos.sv
design/rbp_walk.sv
design/replicate_border_padder_top.sv
tb/sv/rbp_padding_checker.sv
tb/sv/tb_replicate_border_padder_top.sv
